### src/ffra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and constants of the first-fit address range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int TableEntriesDef = 16;

  localparam int AddrW = 48;
  localparam int LenW  = 49;

  typedef enum logic [2:0] {
    FN_ALLOC  = 3'd0,
    FN_FREE   = 3'd1,
    FN_FREEX  = 3'd2,
    FN_QUERY  = 3'd3,
    FN_INIT   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOFIT    = 3'd2,
    ST_OUTSIDE  = 3'd3,
    ST_NOTALLOC = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    CFG_BASE = 1'b0,
    CFG_LEN  = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_REQ,
    S_SCAN_CHK,
    S_DECIDE,
    S_APPEND,
    S_UPD,
    S_SHIFT_REQ,
    S_SHIFT_WR,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

### src/first_fit_range_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// Free and allocated range tables in two memories, walked by one sequencer.
// The walk reads each memory through its one registered read port: it scans
// entries and, when an entry is removed, shifts later entries down over it.
// One operation at a time, busy meanwhile. The result strobe lasts one cycle
// and the receiver cannot stall. Reset empties both tables (counts zero).
// ----------------------------------------------------------------------------
module first_fit_range_allocator
  import ffra_pkg::*;
#(
  parameter int TABLE_ENTRIES = ffra_pkg::TableEntriesDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [2:0]                 func_i,
  input  wire logic [ffra_pkg::AddrW-1:0] address_i,
  input  wire logic [ffra_pkg::LenW-1:0]  length_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic                       cfg_index_i,
  input  wire logic [ffra_pkg::LenW-1:0]  cfg_data_i,
  output logic                            done_o,
  output logic [2:0]                      status_o,
  output logic [ffra_pkg::AddrW-1:0]      range_base_o,
  output logic [ffra_pkg::LenW-1:0]       range_length_o,
  output logic                            addr_hit_o
);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULLC = CW'(TABLE_ENTRIES);
  localparam logic [63:0] AMASK = (64'd1 << AddrW) - 64'd1;
  localparam logic [63:0] LMASK = {AMASK[62:0], 1'b1};

  state_e state_q, state_d;
  logic [AddrW-1:0] wbase_q;
  logic [LenW-1:0]  wlen_q;
  logic [2:0]       func_q;
  logic [AddrW-1:0] addr_q;
  logic [LenW-1:0]  len_q;
  logic [CW-1:0]    fcnt_q, fcnt_d, ucnt_q, ucnt_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             hit_q, hit_d;
  logic [2:0]       st_q, st_d;
  logic [AddrW-1:0] rb_q, rb_d;
  logic [LenW-1:0]  rl_q, rl_d;
  logic [AddrW-1:0] hs_q, hs_d;
  logic [LenW-1:0]  hl_q, hl_d;

  logic            f_we, u_we;
  logic [IW-1:0]   f_wa, u_wa, f_ra, u_ra;
  logic [AddrW-1:0] f_ws, u_ws, f_rs, u_rs;
  logic [LenW-1:0]  f_wl, u_wl, f_rl, u_rl;

  ffra_table #(.Depth(TABLE_ENTRIES), .AW(AddrW), .IdxW(IW)) u_free (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wstart_i(f_ws), .wlen_i(f_wl),
    .raddr_i(f_ra), .rstart_o(f_rs), .rlen_o(f_rl)
  );
  ffra_table #(.Depth(TABLE_ENTRIES), .AW(AddrW), .IdxW(IW)) u_used (
    .clk_i, .we_i(u_we), .waddr_i(u_wa), .wstart_i(u_ws), .wlen_i(u_wl),
    .raddr_i(u_ra), .rstart_o(u_rs), .rlen_o(u_rl)
  );

  logic is_alloc, is_free;
  logic [CW-1:0] cnt;
  logic [63:0] wend, a64, e64;
  logic in_a, in_e, match;
  logic [IW-1:0] idx_i;

  assign is_alloc = (func_q == FN_ALLOC);
  assign is_free  = (func_q == FN_FREE) || (func_q == FN_FREEX);
  assign cnt      = is_alloc ? fcnt_q : ucnt_q;
  assign idx_i    = idx_q[IW-1:0];
  assign wend     = {16'd0, wbase_q} + {15'd0, wlen_q};
  assign a64      = {16'd0, addr_q};
  assign e64      = a64 + {15'd0, len_q} - 64'd1;
  assign in_a     = (a64 >= {16'd0, wbase_q}) && (a64 < wend);
  assign in_e     = (e64 >= {16'd0, wbase_q}) && (e64 < wend);

  always_comb begin
    match = 1'b0;
    case (func_q)
      FN_ALLOC: match = (f_rl >= len_q);
      FN_FREE:  match = (u_rs == addr_q);
      FN_FREEX: match = (u_rs == addr_q) && (u_rl == len_q);
      FN_QUERY: match = (a64 >= {16'd0, u_rs}) &&
                        (a64 < ({16'd0, u_rs} + {15'd0, u_rl}));
      default:  match = 1'b0;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fcnt_q  <= '0;
      ucnt_q  <= '0;
      wbase_q <= '0;
      wlen_q  <= '0;
    end else begin
      state_q <= state_d;
      fcnt_q  <= fcnt_d;
      ucnt_q  <= ucnt_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_BASE) begin
          wbase_q <= AddrW'(cfg_data_i & LenW'(AMASK));
        end else begin
          wlen_q <= cfg_data_i & LenW'(LMASK);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      func_q <= func_i;
      addr_q <= address_i & AddrW'(AMASK);
      len_q  <= length_i & LenW'(LMASK);
    end
    idx_q <= idx_d;
    hit_q <= hit_d;
    st_q  <= st_d;
    rb_q  <= rb_d;
    rl_q  <= rl_d;
    hs_q  <= hs_d;
    hl_q  <= hl_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (start_i) state_d = S_SCAN_REQ;
      S_SCAN_REQ: begin
        if (func_q == FN_INIT) state_d = S_DONE;
        else if (is_alloc && len_q == '0) state_d = S_DONE;
        else if (is_free && !(in_a && (func_q == FN_FREE || in_e))) state_d = S_DONE;
        else if (!(is_alloc || is_free || func_q == FN_QUERY)) state_d = S_DONE;
        else if (idx_q == cnt) state_d = S_DONE;
        else state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: state_d = match ? (func_q == FN_QUERY ? S_DONE : S_DECIDE)
                                  : S_SCAN_REQ;
      S_DECIDE: begin
        if (is_alloc ? (ucnt_q >= FULLC) : (fcnt_q >= FULLC)) state_d = S_DONE;
        else state_d = S_APPEND;
      end
      S_APPEND: state_d = (is_alloc && hl_q != len_q) ? S_UPD : S_SHIFT_REQ;
      S_UPD:    state_d = S_DONE;
      S_SHIFT_REQ: state_d = (idx_q + CW'(1) < cnt) ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR:  state_d = S_SHIFT_REQ;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    fcnt_d = fcnt_q;
    ucnt_d = ucnt_q;
    idx_d  = idx_q;
    hit_d  = hit_q;
    st_d   = st_q;
    rb_d   = rb_q;
    rl_d   = rl_q;
    hs_d   = hs_q;
    hl_d   = hl_q;
    f_we = 1'b0; f_wa = idx_i; f_ws = hs_q; f_wl = hl_q;
    u_we = 1'b0; u_wa = idx_i; u_ws = hs_q; u_wl = hl_q;
    f_ra = idx_i;
    u_ra = idx_i;
    busy_o = (state_q != S_IDLE);
    done_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        idx_d = '0; hit_d = 1'b0; st_d = ST_OK; rb_d = '0; rl_d = '0;
      end
      S_SCAN_REQ: begin
        if (func_q == FN_INIT) begin
          ucnt_d = '0; fcnt_d = CW'(1);
          f_we = 1'b1; f_wa = '0; f_ws = wbase_q; f_wl = wlen_q;
        end else if (is_alloc && len_q == '0) begin
          st_d = ST_ZERO;
        end else if (is_free && !(in_a && (func_q == FN_FREE || in_e))) begin
          st_d = ST_OUTSIDE;
        end else if (idx_q == cnt && (is_alloc || is_free)) begin
          st_d = is_alloc ? ST_NOFIT : ST_NOTALLOC;
        end
      end
      S_SCAN_CHK: begin
        if (match) begin
          hit_d = (func_q == FN_QUERY);
          hs_d = is_alloc ? f_rs : u_rs;
          hl_d = is_alloc ? f_rl : u_rl;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_DECIDE: if (is_alloc ? (ucnt_q >= FULLC) : (fcnt_q >= FULLC)) st_d = ST_FULL;
      S_APPEND: begin
        if (is_alloc) begin
          u_we = 1'b1; u_wa = ucnt_q[IW-1:0]; u_ws = hs_q; u_wl = len_q;
          ucnt_d = ucnt_q + CW'(1);
          rb_d = hs_q; rl_d = len_q;
        end else begin
          f_we = 1'b1; f_wa = fcnt_q[IW-1:0]; f_ws = hs_q; f_wl = hl_q;
          fcnt_d = fcnt_q + CW'(1);
        end
      end
      S_UPD: begin
        f_we = 1'b1;
        f_ws = AddrW'(({16'd0, hs_q} + {15'd0, len_q}) & AMASK);
        f_wl = hl_q - len_q;
      end
      S_SHIFT_REQ: begin
        f_ra = IW'(idx_q + CW'(1));
        u_ra = IW'(idx_q + CW'(1));
        if (!(idx_q + CW'(1) < cnt)) begin
          if (is_alloc) fcnt_d = fcnt_q - CW'(1);
          else ucnt_d = ucnt_q - CW'(1);
        end
      end
      S_SHIFT_WR: begin
        if (is_alloc) begin
          f_we = 1'b1; f_ws = f_rs; f_wl = f_rl;
        end else begin
          u_we = 1'b1; u_ws = u_rs; u_wl = u_rl;
        end
        idx_d = idx_q + CW'(1);
      end
      S_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  assign status_o       = st_q;
  assign range_base_o   = rb_q;
  assign range_length_o = rl_q;
  assign addr_hit_o     = hit_q;
endmodule
`default_nettype wire

### src/ffra_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_table
// One range table: start and length memory with one write and one
// registered read port.
// ----------------------------------------------------------------------------
module ffra_table #(
  parameter int Depth = 16,
  parameter int AW    = 48,
  parameter int IdxW  = 4
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire logic [AW-1:0]   wstart_i,
  input  wire logic [AW:0]     wlen_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output logic      [AW-1:0]   rstart_o,
  output logic      [AW:0]     rlen_o
);
  logic [2*AW:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wstart_i, wlen_i};
    end
    {rstart_o, rlen_o} <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### bench/first_fit_range_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator_tb
// Self-checking bench for the first-fit range allocator: directed tests for
// each operation and corner case, then random mixed traffic (allocate, free,
// query, init and invalid functions) over several window settings, checked
// against a behavioural copy of both range tables.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_tb;
  import ffra_pkg::*;

  localparam int Depth     = 16;
  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] base;
    logic [LenW-1:0]  len;
    logic             hit;
  } alloc_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [2:0]       func_i = '0;
  logic [AddrW-1:0] address_i = '0;
  logic [LenW-1:0]  length_i = '0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_index_i = 1'b0;
  logic [LenW-1:0]  cfg_data_i = '0;
  logic             done_o;
  logic [2:0]       status_o;
  logic [AddrW-1:0] range_base_o;
  logic [LenW-1:0]  range_length_o;
  logic             addr_hit_o;

  first_fit_range_allocator u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .address_i, .length_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .done_o,
    .status_o, .range_base_o, .range_length_o, .addr_hit_o
  );

  // model of the tables
  longint unsigned win_base, win_len;
  logic [AddrW-1:0] free_st [Depth];
  logic [LenW-1:0]  free_ln [Depth];
  logic [AddrW-1:0] used_st [Depth];
  logic [LenW-1:0]  used_ln [Depth];
  int               free_n, used_n;

  alloc_result_t pending_results[$];
  int            mismatches;
  int            results_seen;
  int            items_sent;
  int            fulls_seen;
  int            cycles;
  bit            no_gaps;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, exp);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result, status", status_o, 0);
      end else begin
        e = pending_results.pop_front();
        if (status_o == ST_FULL) fulls_seen++;
        if (status_o != e.status) report("status", status_o, e.status);
        if (range_base_o != e.base) report("range_base", range_base_o, e.base);
        if (range_length_o != e.len) report("range_length", range_length_o, e.len);
        if (addr_hit_o != e.hit) report("addr_hit", addr_hit_o, e.hit);
      end
    end
  end

  function automatic bit in_win(input longint unsigned a);
    return a >= win_base && a < win_base + win_len;
  endfunction

  function automatic void drop_free(input int idx);
    for (int k = idx; k + 1 < free_n; k++) begin
      free_st[k] = free_st[k+1];
      free_ln[k] = free_ln[k+1];
    end
    free_n--;
  endfunction

  function automatic alloc_result_t alloc_predict(input logic [2:0] fn,
                                                  input logic [AddrW-1:0] addr,
                                                  input logic [LenW-1:0] len);
    alloc_result_t r;
    int i;
    bit in_range;
    longint unsigned a64, l64;
    r = '0;
    a64 = addr;
    l64 = len;
    case (fn)
      FN_ALLOC: begin
        if (len == 0) begin
          r.status = ST_ZERO;
        end else begin
          for (i = 0; i < free_n; i++) if (free_ln[i] >= len) break;
          if (i == free_n) r.status = ST_NOFIT;
          else if (used_n >= Depth) r.status = ST_FULL;
          else begin
            r.base = free_st[i];
            r.len = len;
            used_st[used_n] = free_st[i];
            used_ln[used_n] = len;
            used_n++;
            if (free_ln[i] == len) drop_free(i);
            else begin
              free_st[i] = free_st[i] + len[AddrW-1:0];
              free_ln[i] = free_ln[i] - len;
            end
          end
        end
      end
      FN_FREE, FN_FREEX: begin
        if (fn == FN_FREE) in_range = in_win(a64);
        else in_range = in_win(a64) && in_win(a64 + l64 - 1);
        if (!in_range) begin
          r.status = ST_OUTSIDE;
        end else begin
          for (i = 0; i < used_n; i++)
            if (used_st[i] == addr && (fn == FN_FREE || used_ln[i] == len)) break;
          if (i == used_n) r.status = ST_NOTALLOC;
          else if (free_n >= Depth) r.status = ST_FULL;
          else begin
            free_st[free_n] = used_st[i];
            free_ln[free_n] = used_ln[i];
            free_n++;
            for (int k = i; k + 1 < used_n; k++) begin
              used_st[k] = used_st[k+1];
              used_ln[k] = used_ln[k+1];
            end
            used_n--;
          end
        end
      end
      FN_QUERY: begin
        for (i = 0; i < used_n; i++) begin
          if (a64 >= longint'(used_st[i]) &&
              a64 < longint'(used_st[i]) + longint'(used_ln[i])) begin
            r.hit = 1'b1;
            break;
          end
        end
      end
      FN_INIT: begin
        used_n = 0;
        free_st[0] = win_base[AddrW-1:0];
        free_ln[0] = win_len[LenW-1:0];
        free_n = 1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_op(input logic [2:0] fn, input logic [AddrW-1:0] addr,
                         input logic [LenW-1:0] len);
    int gap;
    gap = no_gaps ? 0 :
          ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i   <= 1'b1;
    func_i    <= fn;
    address_i <= addr;
    length_i  <= len;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(alloc_predict(fn, addr, len));
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [LenW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_BASE) win_base = data[AddrW-1:0];
    else win_len = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_window(input logic [AddrW-1:0] b, input logic [LenW-1:0] l);
    settle();
    write_cfg(CFG_BASE, {1'b0, b});
    write_cfg(CFG_LEN, l);
  endtask

  function automatic logic [LenW-1:0] rand_len(input longint unsigned span);
    return LenW'(($urandom_range(0, 3) == 0) ? longint'($urandom_range(1, 8))
                 : longint'({$urandom, $urandom}) % (span / 4 + 1) + 1);
  endfunction

  task automatic test_before_init();
    send_op(FN_ALLOC, '0, 49'd16);
    send_op(FN_QUERY, '0, '0);
    send_op(FN_FREE, '0, '0);
    send_op(FN_FREEX, '0, '0);
  endtask

  task automatic test_basic_ops();
    set_window(48'h1000, 49'h100);
    send_op(FN_INIT, '0, '0);
    send_op(FN_ALLOC, '0, '0);
    send_op(FN_ALLOC, '0, 49'h40);
    send_op(FN_ALLOC, '0, 49'h200);
    send_op(FN_QUERY, 48'h1020, '0);
    send_op(FN_QUERY, 48'h1040, '0);
    send_op(FN_FREE, 48'h0fff, '0);
    send_op(FN_FREEX, 48'h1000, 49'h41);
    send_op(FN_FREEX, 48'h1000, 49'h40);
    send_op(FN_FREE, 48'h1000, '0);
    send_op(FN_ALLOC, '0, 49'hc0);
    send_op(3'd5, 48'hffff_ffff_ffff, {LenW{1'b1}});
    send_op(3'd6, '0, '0);
    send_op(3'd7, 48'h1234, 49'h1);
  endtask

  task automatic test_table_full();
    set_window(48'h0, 49'h1000);
    send_op(FN_INIT, '0, '0);
    for (int k = 0; k < Depth + 1; k++) send_op(FN_ALLOC, '0, 49'h10);
    for (int k = 0; k < Depth; k++) send_op(FN_FREE, 48'h10 * k, '0);
  endtask

  task automatic test_window_extremes();
    set_window(48'h5000, 49'h0);
    send_op(FN_INIT, '0, '0);
    send_op(FN_ALLOC, '0, 49'h1);
    set_window({AddrW{1'b1}} - 48'hf, 49'h1_0000_0000_0000);
    send_op(FN_INIT, '0, '0);
    send_op(FN_ALLOC, '0, 49'h20);
    send_op(FN_QUERY, 48'h8, '0);
    send_op(FN_FREEX, {AddrW{1'b1}} - 48'hf, 49'h20);
    send_op(FN_ALLOC, '0, 49'h1_0000_0000_0000);
    set_window('0, 49'h1_0000_0000_0000);
    send_op(FN_INIT, '0, '0);
    send_op(FN_ALLOC, '0, 49'h1_0000_0000_0000);
    send_op(FN_QUERY, {AddrW{1'b1}}, '0);
    send_op(FN_FREEX, '0, 49'h1_0000_0000_0000);
  endtask

  task automatic test_random(input int count);
    int sel, k;
    longint unsigned span;
    logic [AddrW-1:0] a;
    logic [LenW-1:0] l;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        4:       set_window({AddrW{1'b1}}, 49'h1_0000_0000_0000);
        5:       set_window(AddrW'({$urandom, $urandom}), LenW'(longint'($urandom) << 16));
        default: set_window(AddrW'({$urandom, $urandom}), LenW'($urandom_range(64, 8192)));
      endcase
      span = win_len;
      no_gaps = (ph == 2);
      send_op(FN_INIT, '0, '0);
      for (int n = 0; n < count / 6; n++) begin
        sel = $urandom_range(0, 99);
        k = (used_n > 0) ? $urandom_range(0, used_n - 1) : 0;
        if (sel < 35) begin
          send_op(FN_ALLOC, AddrW'({$urandom, $urandom}),
                  ($urandom_range(0, 19) == 0) ? '0 : rand_len(span));
        end else if (sel < 52 && used_n > 0) begin
          send_op(FN_FREE, used_st[k], LenW'({$urandom, $urandom}));
        end else if (sel < 68 && used_n > 0) begin
          l = ($urandom_range(0, 4) == 0) ? used_ln[k] + 1 : used_ln[k];
          send_op(FN_FREEX, used_st[k], l);
        end else if (sel < 84) begin
          a = (used_n > 0 && $urandom_range(0, 1)) ?
              AddrW'(used_st[k] + $urandom_range(0, 15)) :
              AddrW'(win_base + $urandom_range(0, 255));
          send_op(FN_QUERY, a, '0);
        end else if (sel < 96) begin
          send_op(3'($urandom_range(0, 7)), AddrW'({$urandom, $urandom}),
                  LenW'({$urandom, $urandom}));
        end else begin
          send_op(FN_INIT, '0, '0);
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    fulls_seen = 0;
    cycles = 0;
    no_gaps = 1'b0;
    win_base = 0;
    win_len = 0;
    free_n = 0;
    used_n = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_before_init();
    test_basic_ops();
    test_table_full();
    test_window_extremes();
    test_random(600);
    settle();
    $display("%0d operations sent, %0d results checked, %0d table-full statuses",
             items_sent, results_seen, fulls_seen);
    $display("covered every operation, window extremes and random allocate/free traffic");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
src/ffra_pkg.sv
src/ffra_table.sv
src/first_fit_range_allocator.sv
bench/first_fit_range_allocator_tb.sv
